### hdl/kced_pkg.sv
// Shared types, codes and constants of the key click event detector.
`timescale 1ns / 1ps

package kced_pkg;

   // Default sizes for the top-level parameters.
   localparam int DEF_NUM_KEYS  = 4;
   localparam int DEF_TIME_BITS = 32;

   // Field widths of the items.
   localparam int HELD_BITS = 4;
   localparam int NOW_BITS  = 32;
   localparam int CFG_BITS  = 16;
   localparam int CSR_IDX_BITS = 2;

   // Register reset values.
   localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET   = 16'd20;
   localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET = 16'd800;
   localparam logic [CFG_BITS-1:0] DOUBLE_GAP_RESET = 16'd300;

   // Register indexes.
   localparam logic [CSR_IDX_BITS-1:0] CSR_DEBOUNCE   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LONG_PRESS = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DOUBLE_GAP = 2'd2;

   // Event code bases, the key index is added to them.
   localparam logic [7:0] CODE_SINGLE_BASE = 8'h01;
   localparam logic [7:0] CODE_DOUBLE_BASE = 8'h51;
   localparam logic [7:0] CODE_LONG_BASE   = 8'h81;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_SINGLE = 2'd1,
      EV_DOUBLE = 2'd2,
      EV_LONG   = 2'd3
   } event_kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_CONFIRM = 2'd1,
      MODE_PRESSED = 2'd2,
      MODE_LONG    = 2'd3
   } key_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_SCAN = 2'd1,
      ST_POST = 2'd2
   } ctl_state_type;

   typedef struct packed {
      logic [HELD_BITS-1:0] held_mask;
      logic [NOW_BITS-1:0]  now_ms;
   } req_item_type;

   typedef struct packed {
      logic [1:0] event_kind;
      logic [1:0] key_number;
      logic [7:0] event_code;
   } rsp_item_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic step;
      logic publish;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic key_event;
      logic last_key;
      logic out_free;
   } ctl_status_type;

endpackage

### hdl/kced_ctrl.sv
// Scan controller: accepts an item, walks the keys, hands the result out.
`timescale 1ns / 1ps

module kced_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  kced_pkg::ctl_status_type status,
   output kced_pkg::ctl_cmd_type    cmd
);

   kced_pkg::ctl_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kced_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kced_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = kced_pkg::ST_SCAN;
            end
         end
         kced_pkg::ST_SCAN: begin
            if (status.key_event || status.last_key) begin
               state_in = kced_pkg::ST_POST;
            end
         end
         kced_pkg::ST_POST: begin
            if (status.out_free) begin
               state_in = kced_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kced_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      req_stall   = 1'b1;
      cmd.load    = 1'b0;
      cmd.step    = 1'b0;
      cmd.publish = 1'b0;
      case (state_ff)
         kced_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         kced_pkg::ST_SCAN: begin
            cmd.step = 1'b1;
         end
         kced_pkg::ST_POST: begin
            cmd.publish = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

### hdl/kced_datapath.sv
// Key state store, per-key update logic, registers and result register.
`timescale 1ns / 1ps

module kced_datapath #(
   parameter int NUM_KEYS  = kced_pkg::DEF_NUM_KEYS,
   parameter int TIME_BITS = kced_pkg::DEF_TIME_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  kced_pkg::req_item_type              req_data,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output kced_pkg::rsp_item_type              rsp_data,
   input  logic                                csr_write,
   input  logic [kced_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [kced_pkg::CFG_BITS-1:0]       csr_wdata,
   input  kced_pkg::ctl_cmd_type               cmd,
   output kced_pkg::ctl_status_type            status
);

   localparam int IDX_BITS = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(NUM_KEYS - 1);

   // Configuration registers.
   logic [kced_pkg::CFG_BITS-1:0] debounce_ff, long_press_ff, double_gap_ff;

   // Per-key state.
   kced_pkg::key_mode_type mode_ff    [NUM_KEYS];
   logic                   pending_ff [NUM_KEYS];
   logic [TIME_BITS-1:0]   press_ff   [NUM_KEYS];
   logic [TIME_BITS-1:0]   release_ff [NUM_KEYS];

   // Captured item and scan position.
   logic [TIME_BITS-1:0] now_ff;
   logic [NUM_KEYS-1:0]  held_ff, held_in;
   logic [IDX_BITS-1:0]  idx_ff;

   // Scan result and output register.
   kced_pkg::event_kind_type res_kind_ff;
   logic [IDX_BITS-1:0]      res_key_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   kced_pkg::rsp_item_type   rsp_data_ff, rsp_data_in;

   // Current key update.
   kced_pkg::key_mode_type   mode_cur, mode_in;
   kced_pkg::event_kind_type kind;
   logic                     pend_cur, pend_in, held;
   logic                     press_we, release_we;
   logic [TIME_BITS-1:0]     el_press, el_release;
   logic                     gap_over, debounce_done, long_done;
   logic [7:0]               code_base;

   // Register writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= kced_pkg::DEBOUNCE_RESET;
         long_press_ff <= kced_pkg::LONG_PRESS_RESET;
         double_gap_ff <= kced_pkg::DOUBLE_GAP_RESET;
      end else if (csr_write) begin
         case (csr_index)
            kced_pkg::CSR_DEBOUNCE:   debounce_ff   <= csr_wdata;
            kced_pkg::CSR_LONG_PRESS: long_press_ff <= csr_wdata;
            kced_pkg::CSR_DOUBLE_GAP: double_gap_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Spread the held bits over the keys; keys past the mask are never held.
   always_comb begin
      held_in = '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
         if (i < kced_pkg::HELD_BITS) begin
            held_in[i] = req_data.held_mask[2'(i)];
         end
      end
   end

   // Item capture and scan index.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         now_ff  <= TIME_BITS'(req_data.now_ms);
         held_ff <= held_in;
         idx_ff  <= '0;
      end else if (cmd.step && (idx_ff != LAST_IDX)) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // Wrapping time differences for the visited key.
   assign mode_cur      = mode_ff[idx_ff];
   assign pend_cur      = pending_ff[idx_ff];
   assign held          = held_ff[idx_ff];
   assign el_press      = now_ff - press_ff[idx_ff];
   assign el_release    = now_ff - release_ff[idx_ff];
   assign gap_over      = el_release > TIME_BITS'(double_gap_ff);
   assign debounce_done = el_press >= TIME_BITS'(debounce_ff);
   assign long_done     = el_press >= TIME_BITS'(long_press_ff);

   // Key machine for the visited key.
   always_comb begin
      mode_in    = mode_cur;
      pend_in    = pend_cur;
      press_we   = 1'b0;
      release_we = 1'b0;
      kind       = kced_pkg::EV_NONE;
      case (mode_cur)
         kced_pkg::MODE_IDLE: begin
            if (pend_cur && gap_over) begin
               pend_in = 1'b0;
               kind    = kced_pkg::EV_SINGLE;
            end else if (held) begin
               press_we = 1'b1;
               mode_in  = kced_pkg::MODE_CONFIRM;
            end
         end
         kced_pkg::MODE_CONFIRM: begin
            if (!held) begin
               mode_in = kced_pkg::MODE_IDLE;
            end else if (debounce_done) begin
               press_we = 1'b1;
               mode_in  = kced_pkg::MODE_PRESSED;
            end
         end
         kced_pkg::MODE_PRESSED: begin
            if (!held) begin
               mode_in = kced_pkg::MODE_IDLE;
               if (!pend_cur) begin
                  pend_in    = 1'b1;
                  release_we = 1'b1;
               end else if (!gap_over) begin
                  pend_in = 1'b0;
                  kind    = kced_pkg::EV_DOUBLE;
               end else begin
                  release_we = 1'b1;
               end
            end else if (long_done) begin
               mode_in = kced_pkg::MODE_LONG;
            end
         end
         default: begin
            if (!held) begin
               mode_in = kced_pkg::MODE_IDLE;
               pend_in = 1'b0;
               kind    = kced_pkg::EV_LONG;
            end
         end
      endcase
   end

   // Control state of the keys.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_KEYS; i++) begin
            mode_ff[i]    <= kced_pkg::MODE_IDLE;
            pending_ff[i] <= 1'b0;
         end
      end else if (cmd.step) begin
         mode_ff[idx_ff]    <= mode_in;
         pending_ff[idx_ff] <= pend_in;
      end
   end

   // Time stamps of the keys.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_KEYS; i++) begin
            press_ff[i]   <= '0;
            release_ff[i] <= '0;
         end
      end else if (cmd.step) begin
         if (press_we) begin
            press_ff[idx_ff] <= now_ff;
         end
         if (release_we) begin
            release_ff[idx_ff] <= now_ff;
         end
      end
   end

   // Scan result: the first key with an event ends the scan.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_kind_ff <= kced_pkg::EV_NONE;
         res_key_ff  <= '0;
      end else if (cmd.step && (kind != kced_pkg::EV_NONE)) begin
         res_kind_ff <= kind;
         res_key_ff  <= idx_ff;
      end
   end

   // Event code from the kind and the key index.
   always_comb begin
      case (res_kind_ff)
         kced_pkg::EV_SINGLE: code_base = kced_pkg::CODE_SINGLE_BASE;
         kced_pkg::EV_DOUBLE: code_base = kced_pkg::CODE_DOUBLE_BASE;
         kced_pkg::EV_LONG:   code_base = kced_pkg::CODE_LONG_BASE;
         default:             code_base = 8'h00;
      endcase
   end

   // Output register, loaded when it is empty or being taken.
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (res_kind_ff == kced_pkg::EV_NONE) begin
         rsp_data_in.event_kind = 2'(kced_pkg::EV_NONE);
         rsp_data_in.key_number = 2'd0;
         rsp_data_in.event_code = 8'h00;
      end else begin
         rsp_data_in.event_kind = 2'(res_kind_ff);
         rsp_data_in.key_number = 2'(res_key_ff);
         rsp_data_in.event_code = 8'(code_base + 8'(res_key_ff));
      end
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_data_ff;
   assign status.key_event = cmd.step && (kind != kced_pkg::EV_NONE);
   assign status.last_key  = idx_ff == LAST_IDX;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   // A published item shows as valid on the next cycle.
   a_publish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid_ff)
      else $error("published item not presented");

   // The scan advances one key per step until the last key.
   a_scan_advance: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && !cmd.load && (idx_ff != LAST_IDX)) |=>
         (idx_ff == $past(idx_ff) + 1'b1))
      else $error("scan index did not advance");

   // An item without an event carries all-zero fields.
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.event_kind == 2'(kced_pkg::EV_NONE))) |->
         ((rsp_data_ff.event_code == 8'h00) && (rsp_data_ff.key_number == 2'd0)))
      else $error("empty result has nonzero fields");

endmodule

### hdl/key_click_event_detector_core.sv
// Top level of the key click event detector: controller plus datapath.
//
//   Channel  Direction  Handshake                Payload
//   req      in         req_valid / req_stall    req_data  (held_mask, now_ms)
//   rsp      out        rsp_valid / rsp_stall    rsp_data  (event_kind, key_number, event_code)
//   csr      in         csr_valid / csr_ready    csr_index, csr_wdata
//
// One item passes through the accept state, a visit to each scanned key through the shared key
// update logic, and the loading of the output register.
// A scan stops at the first key with an event or at the last key.
// Reset is synchronous: all keys go idle with no pending click, registers take defaults.
// A new item is accepted while the previous result waits in the output register;
// a scan result waits for the output register to free up when rsp_stall is high.
`timescale 1ns / 1ps

module key_click_event_detector_core #(
   parameter int NUM_KEYS  = kced_pkg::DEF_NUM_KEYS,
   parameter int TIME_BITS = kced_pkg::DEF_TIME_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  kced_pkg::req_item_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output kced_pkg::rsp_item_type             rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [kced_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [kced_pkg::CFG_BITS-1:0]      csr_wdata
);

   kced_pkg::ctl_cmd_type    cmd;
   kced_pkg::ctl_status_type status;

   // Register writes are taken in any cycle.
   assign csr_ready = 1'b1;

   kced_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   kced_datapath #(
      .NUM_KEYS  (NUM_KEYS),
      .TIME_BITS (TIME_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
